>>> rtl/core/xor_masked_gps_frame_decoder_top_defines.svh
// shared assertion macros for the frame decoder
`ifndef XOR_MASKED_GPS_FRAME_DECODER_TOP_DEFINES_SVH
`define XOR_MASKED_GPS_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define XMGFD_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("frame decoder check failed");

// next-cycle implication, checked outside reset
`define XMGFD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("frame decoder check failed");

`endif

>>> rtl/core/xmgfd_pkg.sv
package xmgfd_pkg;

  localparam int PAYLOAD_MAX = 256;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] ID_NAV      = 8'h10;
  localparam logic [7:0] ID_MAG      = 8'h20;

  // kept payload bytes: positions 0..41, then 48, 50 and 55
  localparam int SNAP_N   = 45;
  localparam int SNAP_SATS = 42;
  localparam int SNAP_FIX  = 43;
  localparam int SNAP_MASK = 44;

  localparam logic [3:0] KIND_ERR   = 4'd0;
  localparam logic [3:0] KIND_OK    = 4'd1;
  localparam logic [3:0] KIND_LON   = 4'd2;
  localparam logic [3:0] KIND_PDOP  = 4'd10;
  localparam logic [3:0] KIND_SATS  = 4'd11;
  localparam logic [3:0] KIND_FIX   = 4'd12;
  localparam logic [3:0] KIND_MAG_X = 4'd13;

  localparam logic [7:0] ERR_LEN = 8'd0;
  localparam logic [7:0] ERR_CKA = 8'd1;
  localparam logic [7:0] ERR_CKB = 8'd2;

  localparam logic [3:0] NAV_RESULTS = 4'd11;
  localparam logic [3:0] MAG_RESULTS = 4'd3;

  typedef logic [SNAP_N-1:0][7:0] snap_t;

  typedef enum logic [1:0] {
    JOB_ERR = 2'd0,
    JOB_OK  = 2'd1,
    JOB_NAV = 2'd2,
    JOB_MAG = 2'd3
  } job_e;

  typedef struct packed {
    job_e       jk;
    logic [7:0] code;
    snap_t      snap;
  } job_t;

  function automatic logic [7:0] pos_of(input int k);
    logic [7:0] p;
    if (k < 42) p = 8'(k);
    else if (k == SNAP_SATS) p = 8'd48;
    else if (k == SNAP_FIX) p = 8'd50;
    else p = 8'd55;
    return p;
  endfunction

  function automatic logic [31:0] unmask_word(input snap_t s, input int base,
                                              input logic [7:0] m);
    return {s[base+3] ^ m, s[base+2] ^ m, s[base+1] ^ m, s[base] ^ m};
  endfunction

endpackage

>>> rtl/core/xmgfd_front.sv
module xmgfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    rx_byte_i,
  output logic          push_o,
  output xmgfd_pkg::job_t job_o
);
  import xmgfd_pkg::*;

  typedef enum logic [6:0] {
    ST_HUNT1 = 7'b0000001,
    ST_HUNT2 = 7'b0000010,
    ST_ID    = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_PAY   = 7'b0010000,
    ST_CKA   = 7'b0100000,
    ST_CKB   = 7'b1000000
  } step_e;

  step_e      step_q;
  logic [7:0] sum_a_q, sum_b_q, id_q, len_q;
  logic [8:0] count_q;
  logic       bad_q;
  snap_t      store_q;

  logic [7:0] a_next;
  logic [8:0] count_next;

  assign a_next     = sum_a_q + rx_byte_i;
  assign count_next = count_q + 9'd1;

  always_comb begin
    push_o     = 1'b0;
    job_o.jk   = JOB_ERR;
    job_o.code = ERR_LEN;
    job_o.snap = store_q;
    if (take_i) begin
      case (step_q)
        ST_LEN: begin
          push_o = {2'b00, rx_byte_i} > 10'(PAYLOAD_MAX);
        end
        ST_CKB: begin
          push_o = 1'b1;
          if (sum_b_q != rx_byte_i) begin
            job_o.code = ERR_CKB;
          end else if (bad_q) begin
            job_o.code = ERR_CKA;
          end else if (id_q == ID_NAV) begin
            job_o.jk = JOB_NAV;
          end else if (id_q == ID_MAG) begin
            job_o.jk = JOB_MAG;
          end else begin
            job_o.jk   = JOB_OK;
            job_o.code = id_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_HUNT1;
      sum_a_q <= '0;
      sum_b_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      count_q <= '0;
      bad_q   <= 1'b0;
      store_q <= '0;
    end else if (take_i) begin
      case (step_q)
        ST_HUNT1: begin
          if (rx_byte_i == SYNC_FIRST) begin
            bad_q  <= 1'b0;
            step_q <= ST_HUNT2;
          end
        end
        ST_HUNT2: step_q <= (rx_byte_i == SYNC_SECOND) ? ST_ID : ST_HUNT1;
        ST_ID: begin
          sum_a_q <= rx_byte_i;
          sum_b_q <= rx_byte_i;
          id_q    <= rx_byte_i;
          step_q  <= ST_LEN;
        end
        ST_LEN: begin
          sum_a_q <= a_next;
          sum_b_q <= sum_b_q + a_next;
          len_q   <= rx_byte_i;
          count_q <= '0;
          if ({2'b00, rx_byte_i} > 10'(PAYLOAD_MAX)) step_q <= ST_HUNT1;
          else if (rx_byte_i == 8'd0) step_q <= ST_CKB;
          else step_q <= ST_PAY;
        end
        ST_PAY: begin
          sum_a_q <= a_next;
          sum_b_q <= sum_b_q + a_next;
          // only the byte positions the decoder looks at are kept
          for (int k = 0; k < SNAP_N; k++) begin
            if (count_q == {1'b0, pos_of(k)}) store_q[k] <= rx_byte_i;
          end
          count_q <= count_next;
          if (count_next >= {1'b0, len_q}) step_q <= ST_CKA;
        end
        ST_CKA: begin
          step_q <= ST_CKB;
          if (sum_a_q != rx_byte_i) bad_q <= 1'b1;
        end
        ST_CKB: step_q <= ST_HUNT1;
        default: step_q <= ST_HUNT1;
      endcase
    end
  end

endmodule

>>> rtl/core/xmgfd_queue.sv
module xmgfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xmgfd_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            nonempty_o,
  output xmgfd_pkg::job_t head_o
);
  import xmgfd_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q[1];
  assign nonempty_o = cnt_q != 2'd0;
  assign head_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> rtl/core/xmgfd_back.sv
module xmgfd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  xmgfd_pkg::job_t    job_i,
  input  logic               stall_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic [3:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic               new_fix_o,
  output logic               last_o
);
  import xmgfd_pkg::*;

  logic [3:0] idx_q;
  logic [3:0] count;
  logic [7:0] nm, mm, z, fx;
  logic [31:0] val;

  assign valid_o = avail_i;

  always_comb begin
    case (job_i.jk)
      JOB_NAV: count = NAV_RESULTS;
      JOB_MAG: count = MAG_RESULTS;
      default: count = 4'd1;
    endcase
  end

  assign last_o = idx_q == count - 4'd1;
  assign pop_o  = avail_i && !stall_i && last_o;

  // magnetometer mask mixed from the low byte of z
  assign z  = job_i.snap[4];
  assign mm = (((z ^ (z >> 4)) & 8'h0F) | ((z << 3) & 8'hF0)) ^ {z[0], 3'b000, z[0], 3'b000};
  assign nm = job_i.snap[SNAP_MASK];
  assign fx = job_i.snap[SNAP_FIX] ^ nm;

  always_comb begin
    kind_o    = KIND_ERR;
    val       = {24'd0, job_i.code};
    new_fix_o = 1'b0;
    case (job_i.jk)
      JOB_OK: kind_o = KIND_OK;
      JOB_NAV: begin
        kind_o = KIND_LON + idx_q;
        case (idx_q)
          4'd0: val = unmask_word(job_i.snap, 4, nm);
          4'd1: val = unmask_word(job_i.snap, 8, nm);
          4'd2: val = unmask_word(job_i.snap, 12, nm);
          4'd3: val = unmask_word(job_i.snap, 16, nm);
          4'd4: val = unmask_word(job_i.snap, 20, nm);
          4'd5: val = unmask_word(job_i.snap, 28, nm);
          4'd6: val = unmask_word(job_i.snap, 32, nm);
          4'd7: val = unmask_word(job_i.snap, 36, nm);
          4'd8: val = {16'd0, job_i.snap[41] ^ nm, job_i.snap[40] ^ nm};
          4'd9: val = {24'd0, job_i.snap[SNAP_SATS]};
          default: begin
            new_fix_o = 1'b1;
            val = (fx == 8'd2) ? 32'd1 : (fx == 8'd3) ? 32'd2 : 32'd0;
          end
        endcase
      end
      JOB_MAG: begin
        kind_o = KIND_MAG_X + idx_q;
        case (idx_q)
          4'd0: val = {{16{job_i.snap[1][7] ^ mm[7]}}, job_i.snap[1] ^ mm, job_i.snap[0] ^ mm};
          4'd1: val = {{16{job_i.snap[3][7] ^ mm[7]}}, job_i.snap[3] ^ mm, job_i.snap[2] ^ mm};
          default: val = {{16{job_i.snap[5][7] ^ mm[7]}}, job_i.snap[5] ^ mm, job_i.snap[4]};
        endcase
      end
      default: ;
    endcase
  end

  assign value_o = $signed(val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (avail_i && !stall_i) begin
      idx_q <= last_o ? 4'd0 : idx_q + 4'd1;
    end
  end

endmodule

>>> rtl/core/xor_masked_gps_frame_decoder_top.sv
// masked binary gps frame decoder
// input: one received byte per request on rx_byte_i, valid/stall handshake;
//   a request is taken at a clock edge with in_valid_i high and in_stall_o low
// output: result requests (kind, value, new_fix, last) on the out channel,
//   taken when out_valid_o is high and out_stall_i is low
// throughput: one byte per cycle sustained; the parser never waits on the
//   result side unless two finished frames are already queued
// a frame's result entry is written into the queue when its last checksum
//   byte is taken, and its first result is offered once it heads the queue
// a navigation frame drains eleven results, one per cycle while out_stall_i
//   is low, a magnetometer frame three, any other outcome one; the drain rate
//   is set by the single result port reading the two-entry frame queue
// the parser keeps the payload bytes it needs in registers and copies them
//   into the queue at frame end, so the next frame may arrive during a drain
// reset clears the parser, sums and kept payload bytes and empties the queue
// when the receiver stalls the offered result holds; once the queue fills,
//   in_stall_o rises until an entry has fully drained
`include "xor_masked_gps_frame_decoder_top_defines.svh"

module xor_masked_gps_frame_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic               new_fix_o,
  output logic               last_o
);
  import xmgfd_pkg::*;

  logic take, push, pop, full, nonempty;
  job_t job, head;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  xmgfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .job_o     (job)
  );

  xmgfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (job),
    .pop_i      (pop),
    .full_o     (full),
    .nonempty_o (nonempty),
    .head_o     (head)
  );

  xmgfd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .avail_i   (nonempty),
    .job_i     (head),
    .stall_i   (out_stall_i),
    .pop_o     (pop),
    .valid_o   (out_valid_o),
    .kind_o    (kind_o),
    .value_o   (value_o),
    .new_fix_o (new_fix_o),
    .last_o    (last_o)
  );

  `XMGFD_ASSERT_NOW(a_fix_is_last, out_valid_o && new_fix_o, last_o && kind_o == KIND_FIX)
  `XMGFD_ASSERT_NOW(a_err_single, out_valid_o && kind_o == KIND_ERR, last_o)
  `XMGFD_ASSERT_NOW(a_stall_full, in_stall_o, out_valid_o)
  `XMGFD_ASSERT_NEXT(a_drain_hold, out_valid_o && out_stall_i, out_valid_o)

endmodule
